FILE: hw/rtl/cse_pkg.sv
// Shared types, constants and rounding helpers for the Chebyshev series evaluator.
`default_nettype none

package cse_pkg;

  // Default sizes of the coefficient store, term tables and components.
  localparam int unsigned COEF_DEPTH_DEF = 1024;
  localparam int unsigned MAX_TERMS_DEF  = 32;
  localparam int unsigned MAX_COMP_DEF   = 3;

  // Datapath widths.
  localparam int unsigned OP_W   = 33;
  localparam int unsigned PROD_W = 2 * OP_W;
  localparam int unsigned ACC_W  = 128;
  localparam int unsigned CFG_IDX_W = 3;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_NUM_TERMS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COMP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_SUBINT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WANT_VEL    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VEL_SCALE   = 3'd4;

  // Request kinds.
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_EVAL = 1'b1;

  typedef struct packed {
    logic               action;
    logic [9:0]         coef_index;
    logic signed [63:0] coef_value;
    logic [32:0]        time_fraction;
  } in_req_t;

  typedef struct packed {
    logic [1:0]         component;
    logic signed [63:0] position;
    logic signed [63:0] velocity;
    logic               last;
  } out_res_t;

  // Effective configuration handed to the sequencer (term count goes separately).
  typedef struct packed {
    logic [1:0]         num_comp;
    logic [4:0]         num_subint;
    logic               want_vel;
    logic signed [63:0] vel_scale;
  } cse_cfg_t;

  typedef enum logic {
    ACC_POS = 1'b0,
    ACC_VEL = 1'b1
  } acc_sel_t;

  typedef enum logic [1:0] {
    SH_0  = 2'd0,
    SH_32 = 2'd1,
    SH_64 = 2'd2
  } sh_t;

  // One partial product request to the multiply-accumulate unit.
  typedef struct packed {
    logic                    issue;
    acc_sel_t                dst;
    sh_t                     sh;
    logic                    clr_pos;
    logic                    clr_vel;
    logic signed [OP_W-1:0]  a;
    logic signed [OP_W-1:0]  b;
  } mac_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_BASE,
    ST_INIT0,
    ST_INIT1,
    ST_REC,
    ST_MREAD,
    ST_MMUL,
    ST_MDRAIN,
    ST_VLATCH,
    ST_VMUL,
    ST_VDRAIN,
    ST_FINISH
  } state_t;

  // Round x / 2^n half toward plus infinity and saturate to 64 bits signed.
  function automatic logic signed [63:0] round_sat(input logic signed [ACC_W-1:0] x,
                                                   input int unsigned n);
    logic signed [ACC_W-1:0] y;
    logic signed [ACC_W-1:0] smax;
    logic signed [ACC_W-1:0] smin;
    smax = ACC_W'(64'h7FFF_FFFF_FFFF_FFFF);
    smin = -smax - ACC_W'(1);
    y = x + signed'(ACC_W'(1) << (n - 1));
    y = y >>> n;
    if (y > smax) begin
      round_sat = 64'h7FFF_FFFF_FFFF_FFFF;
    end else if (y < smin) begin
      round_sat = 64'h8000_0000_0000_0000;
    end else begin
      round_sat = y[63:0];
    end
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/chebyshev_series_eval.sv
// Top level of the Chebyshev series evaluator: configuration registers and units.
// A load is written to the store without making the block busy. An evaluation runs
// setup, the base search over sub-intervals and wraps of the base, the table init and
// the recurrence (only for nt above 2), then per component the multiply pass and, with
// velocity on, the scaling pass before that component's result is issued. The pace is
// set by the single 33x33 multiplier: six partial products per term and memory read.
// One evaluation at a time; busy is high until the last result is issued.
// Synchronous active-low reset puts the sequencer in idle and the registers at defaults.
`default_nettype none

module chebyshev_series_eval #(
  parameter int unsigned COEF_DEPTH     = cse_pkg::COEF_DEPTH_DEF,
  parameter int unsigned MAX_TERMS      = cse_pkg::MAX_TERMS_DEF,
  parameter int unsigned MAX_COMPONENTS = cse_pkg::MAX_COMP_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire cse_pkg::in_req_t                in_req,
  output logic                                 out_valid,
  output cse_pkg::out_res_t                    out_res,
  input  wire logic                            cfg_we,
  input  wire logic [cse_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [63:0]                     cfg_wdata
);
  import cse_pkg::*;

  localparam int unsigned NTW = $clog2(MAX_TERMS + 1);

  logic [5:0]          num_terms_r;
  logic [1:0]          num_comp_r;
  logic [4:0]          num_subint_r;
  logic                want_vel_r;
  logic signed [63:0]  vel_scale_r;
  logic [NTW-1:0]      nt_eff;
  cse_cfg_t            cfg_eff;
  mac_cmd_t            mac_cmd;
  logic signed [ACC_W-1:0] acc_pos;
  logic signed [ACC_W-1:0] acc_vel;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_terms_r  <= 6'd18;
      num_comp_r   <= 2'd1;
      num_subint_r <= 5'd1;
      want_vel_r   <= 1'b1;
      vel_scale_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NUM_TERMS:  num_terms_r  <= cfg_wdata[5:0];
        REG_NUM_COMP:   num_comp_r   <= cfg_wdata[1:0];
        REG_NUM_SUBINT: num_subint_r <= cfg_wdata[4:0];
        REG_WANT_VEL:   want_vel_r   <= cfg_wdata[0];
        REG_VEL_SCALE:  vel_scale_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Counts limited to what the hardware supports.
  always_comb begin
    if (num_terms_r == '0) begin
      nt_eff = NTW'(1);
    end else if (7'(num_terms_r) > 7'(MAX_TERMS)) begin
      nt_eff = NTW'(MAX_TERMS);
    end else begin
      nt_eff = NTW'(num_terms_r);
    end
    if (num_comp_r == '0) begin
      cfg_eff.num_comp = 2'd1;
    end else if (num_comp_r > 2'(MAX_COMPONENTS)) begin
      cfg_eff.num_comp = 2'(MAX_COMPONENTS);
    end else begin
      cfg_eff.num_comp = num_comp_r;
    end
    cfg_eff.num_subint = (num_subint_r == '0) ? 5'd1 : num_subint_r;
    cfg_eff.want_vel   = want_vel_r;
    cfg_eff.vel_scale  = vel_scale_r;
  end

  cse_ctrl #(
    .COEF_DEPTH     (COEF_DEPTH),
    .MAX_TERMS      (MAX_TERMS),
    .MAX_COMPONENTS (MAX_COMPONENTS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .nt        (nt_eff),
    .cfg       (cfg_eff),
    .out_valid (out_valid),
    .out_res   (out_res),
    .mac_cmd   (mac_cmd),
    .acc_pos   (acc_pos),
    .acc_vel   (acc_vel)
  );

  cse_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (mac_cmd),
    .acc_pos (acc_pos),
    .acc_vel (acc_vel)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/cse_mac.sv
// Shared 33x33 signed multiplier with two wide accumulators for the evaluator.
`default_nettype none

module cse_mac (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire cse_pkg::mac_cmd_t                  cmd,
  output logic signed [cse_pkg::ACC_W-1:0]        acc_pos,
  output logic signed [cse_pkg::ACC_W-1:0]        acc_vel
);
  import cse_pkg::*;

  logic signed [OP_W-1:0]   a_s;
  logic signed [OP_W-1:0]   b_s;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] prod_r;
  logic                     pvld_r;
  acc_sel_t                 pdst_r;
  sh_t                      psh_r;
  logic signed [ACC_W-1:0]  addend;
  logic signed [ACC_W-1:0]  acc_pos_r;
  logic signed [ACC_W-1:0]  acc_vel_r;

  // Multiply stage, registered before accumulation.
  assign a_s      = cmd.a;
  assign b_s      = cmd.b;
  assign prod_nxt = a_s * b_s;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    pdst_r <= cmd.dst;
    psh_r  <= cmd.sh;
    if (!rst_n) begin
      pvld_r <= 1'b0;
    end else begin
      pvld_r <= cmd.issue;
    end
  end

  // Align the partial product to its weight.
  always_comb begin
    case (psh_r)
      SH_0:    addend = ACC_W'(prod_r);
      SH_32:   addend = ACC_W'(prod_r) <<< 32;
      SH_64:   addend = ACC_W'(prod_r) <<< 64;
      default: addend = '0;
    endcase
  end

  // Accumulate; clears come only when no product is in flight.
  always_ff @(posedge clk) begin
    if (cmd.clr_pos) begin
      acc_pos_r <= '0;
    end else if (pvld_r && pdst_r == ACC_POS) begin
      acc_pos_r <= acc_pos_r + addend;
    end
    if (cmd.clr_vel) begin
      acc_vel_r <= '0;
    end else if (pvld_r && pdst_r == ACC_VEL) begin
      acc_vel_r <= acc_vel_r + addend;
    end
  end

  assign acc_pos = acc_pos_r;
  assign acc_vel = acc_vel_r;

endmodule

`default_nettype wire

FILE: hw/rtl/cse_ctrl.sv
// Sequencer with coefficient and term memories for the Chebyshev series evaluator.
`default_nettype none

module cse_ctrl #(
  parameter int unsigned COEF_DEPTH     = cse_pkg::COEF_DEPTH_DEF,
  parameter int unsigned MAX_TERMS      = cse_pkg::MAX_TERMS_DEF,
  parameter int unsigned MAX_COMPONENTS = cse_pkg::MAX_COMP_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire cse_pkg::in_req_t                   in_req,
  input  wire logic [$clog2(MAX_TERMS+1)-1:0]     nt,
  input  wire cse_pkg::cse_cfg_t                  cfg,
  output logic                                    out_valid,
  output cse_pkg::out_res_t                       out_res,
  output cse_pkg::mac_cmd_t                       mac_cmd,
  input  wire logic signed [cse_pkg::ACC_W-1:0]   acc_pos,
  input  wire logic signed [cse_pkg::ACC_W-1:0]   acc_vel
);
  import cse_pkg::*;

  localparam int unsigned AW  = $clog2(COEF_DEPTH);
  localparam int unsigned KW  = $clog2(MAX_TERMS);
  localparam int unsigned NTW = $clog2(MAX_TERMS + 1);
  localparam int unsigned SW  = $clog2(MAX_TERMS * MAX_COMPONENTS + 1);
  localparam int unsigned BW  = $clog2(COEF_DEPTH + MAX_TERMS * MAX_COMPONENTS + 1);
  localparam int unsigned XW  = AW + 10;
  localparam int unsigned TVW = 72;

  // Memories: coefficients, and the T/V term table as {T, V}.
  logic [63:0]     coef_mem [COEF_DEPTH];
  logic [TVW-1:0]  tv_mem   [MAX_TERMS];

  state_t state_r, state_nxt;
  logic [2:0]              pc_r;
  logic [NTW-1:0]          k_r;
  logic [1:0]              c_r;
  logic [4:0]              lcnt_r;
  logic [32:0]             t_r;
  logic signed [32:0]      tc_r;
  logic [BW-1:0]           base_r;
  logic [AW-1:0]           addr_r;
  logic signed [31:0]      tm1_r, tm2_r;
  logic signed [39:0]      vm1_r, vm2_r;
  logic signed [63:0]      sv_r;
  logic [63:0]             cf_q;
  logic [TVW-1:0]          tv_q;
  logic                    out_valid_r;
  out_res_t                out_res_r;

  logic                    accept;
  logic [XW-1:0]           idx_ext;
  logic [32:0]             t_sat;
  logic [37:0]             prod_na;
  logic                    dt1;
  logic [4:0]              l_w;
  logic signed [33:0]      tc_w;
  logic signed [33:0]      t1_w;
  logic [SW-1:0]           stride;
  logic                    k_last;
  logic [AW-1:0]           addr_inc;
  logic signed [63:0]      rs_t, rs_v;
  logic signed [65:0]      p_w, v_w;
  logic signed [31:0]      t_new;
  logic signed [39:0]      v_new;
  logic                    tv_we;
  logic [KW-1:0]           tv_wa;
  logic [TVW-1:0]          tv_wd;
  logic signed [OP_W-1:0]  tq_s, clo, chi, vlo_q, vhi_q, vlo_m, vhi_m;
  logic signed [OP_W-1:0]  svlo, svhi, slo, shi;

  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // Input time saturated to one.
  assign t_sat  = (in_req.time_fraction[32] && in_req.time_fraction[31:0] != '0) ?
                  33'h1_0000_0000 : in_req.time_fraction;
  assign idx_ext = XW'(in_req.coef_index);

  // Sub-interval and normalized time.
  assign dt1     = (t_r == 33'h1_0000_0000);
  assign prod_na = 38'(cfg.num_subint) * 38'(t_r);
  assign l_w     = prod_na[36:32] - 5'(dt1);
  assign tc_w    = signed'({1'b0, dt1, prod_na[31:0]}) - 34'sd2147483648;
  assign t1_w    = (34'(tc_r) + 34'sd1) >>> 1;

  assign stride   = SW'(SW'(nt) * SW'(cfg.num_comp));
  assign k_last   = ((k_r + NTW'(1)) == nt);
  assign addr_inc = (addr_r == AW'(COEF_DEPTH - 1)) ? '0 : addr_r + AW'(1);

  // Recurrence step: T_k and V_k from the accumulated products.
  always_comb begin
    rs_t = round_sat(acc_pos, 30);
    rs_v = round_sat(acc_vel, 30);
    p_w  = 66'(rs_t) - 66'(tm2_r);
    v_w  = 66'(rs_v) + 66'(tm1_r) - 66'(vm2_r);
    if (p_w > 66'sh7FFF_FFFF) begin
      t_new = 32'sh7FFF_FFFF;
    end else if (p_w < -66'sh8000_0000) begin
      t_new = 32'sh8000_0000;
    end else begin
      t_new = p_w[31:0];
    end
    if (v_w > 66'sh7F_FFFF_FFFF) begin
      v_new = 40'sh7F_FFFF_FFFF;
    end else if (v_w < -66'sh80_0000_0000) begin
      v_new = 40'sh80_0000_0000;
    end else begin
      v_new = v_w[39:0];
    end
  end

  // Operand slices for the shared multiplier.
  assign tq_s  = OP_W'(signed'(tv_q[71:40]));
  assign vlo_q = signed'({1'b0, tv_q[31:0]});
  assign vhi_q = OP_W'(signed'(tv_q[39:32]));
  assign clo   = signed'({1'b0, cf_q[31:0]});
  assign chi   = OP_W'(signed'(cf_q[63:32]));
  assign vlo_m = signed'({1'b0, vm1_r[31:0]});
  assign vhi_m = OP_W'(signed'(vm1_r[39:32]));
  assign svlo  = signed'({1'b0, sv_r[31:0]});
  assign svhi  = OP_W'(signed'(sv_r[63:32]));
  assign slo   = signed'({1'b0, cfg.vel_scale[31:0]});
  assign shi   = OP_W'(signed'(cfg.vel_scale[63:32]));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (start && in_req.action == ACT_EVAL) state_nxt = ST_SETUP;
      ST_SETUP:  state_nxt = ST_BASE;
      ST_BASE: begin
        if (base_r < BW'(COEF_DEPTH) && lcnt_r == '0) state_nxt = ST_INIT0;
      end
      ST_INIT0:  state_nxt = ST_INIT1;
      ST_INIT1:  state_nxt = (nt > NTW'(2)) ? ST_REC : ST_MREAD;
      ST_REC:    if (pc_r == 3'd4 && k_last) state_nxt = ST_MREAD;
      ST_MREAD:  state_nxt = ST_MMUL;
      ST_MMUL:   if (pc_r == 3'd5) state_nxt = k_last ? ST_MDRAIN : ST_MREAD;
      ST_MDRAIN: state_nxt = ST_VLATCH;
      ST_VLATCH: state_nxt = cfg.want_vel ? ST_VMUL : ST_FINISH;
      ST_VMUL:   if (pc_r == 3'd3) state_nxt = ST_VDRAIN;
      ST_VDRAIN: state_nxt = ST_FINISH;
      ST_FINISH: state_nxt = ((c_r + 2'd1) == cfg.num_comp) ? ST_IDLE : ST_MREAD;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Multiplier requests and term table writes.
  always_comb begin
    mac_cmd         = '0;
    mac_cmd.dst     = ACC_POS;
    mac_cmd.sh      = SH_0;
    tv_we           = 1'b0;
    tv_wa           = k_r[KW-1:0];
    tv_wd           = {t_new, v_new};
    case (state_r)
      ST_INIT0: begin
        tv_we = 1'b1;
        tv_wa = '0;
        tv_wd = {32'sh4000_0000, 40'sh0};
      end
      ST_INIT1: begin
        tv_we = 1'b1;
        tv_wa = KW'(1);
        tv_wd = {t1_w[31:0], 40'sh00_2000_0000};
        mac_cmd.clr_pos = 1'b1;
        mac_cmd.clr_vel = 1'b1;
      end
      ST_REC: begin
        mac_cmd.a = tc_r;
        case (pc_r)
          3'd0: begin
            mac_cmd.issue = 1'b1;
            mac_cmd.b     = OP_W'(tm1_r);
          end
          3'd1: begin
            mac_cmd.issue = 1'b1;
            mac_cmd.dst   = ACC_VEL;
            mac_cmd.b     = vlo_m;
          end
          3'd2: begin
            mac_cmd.issue = 1'b1;
            mac_cmd.dst   = ACC_VEL;
            mac_cmd.sh    = SH_32;
            mac_cmd.b     = vhi_m;
          end
          3'd4: begin
            tv_we           = 1'b1;
            mac_cmd.clr_pos = 1'b1;
            mac_cmd.clr_vel = 1'b1;
          end
          default: mac_cmd.issue = 1'b0;
        endcase
      end
      ST_MMUL: begin
        mac_cmd.issue = 1'b1;
        case (pc_r)
          3'd0: begin
            mac_cmd.a = tq_s;  mac_cmd.b = clo;
          end
          3'd1: begin
            mac_cmd.a = tq_s;  mac_cmd.b = chi;  mac_cmd.sh = SH_32;
          end
          3'd2: begin
            mac_cmd.a = vlo_q; mac_cmd.b = clo;  mac_cmd.dst = ACC_VEL;
          end
          3'd3: begin
            mac_cmd.a = vlo_q; mac_cmd.b = chi;  mac_cmd.dst = ACC_VEL;
            mac_cmd.sh = SH_32;
          end
          3'd4: begin
            mac_cmd.a = vhi_q; mac_cmd.b = clo;  mac_cmd.dst = ACC_VEL;
            mac_cmd.sh = SH_32;
          end
          default: begin
            mac_cmd.a = vhi_q; mac_cmd.b = chi;  mac_cmd.dst = ACC_VEL;
            mac_cmd.sh = SH_64;
          end
        endcase
      end
      ST_VLATCH: mac_cmd.clr_vel = 1'b1;
      ST_VMUL: begin
        mac_cmd.issue = 1'b1;
        mac_cmd.dst   = ACC_VEL;
        case (pc_r)
          3'd0: begin
            mac_cmd.a = svlo; mac_cmd.b = slo;
          end
          3'd1: begin
            mac_cmd.a = svlo; mac_cmd.b = shi; mac_cmd.sh = SH_32;
          end
          3'd2: begin
            mac_cmd.a = svhi; mac_cmd.b = slo; mac_cmd.sh = SH_32;
          end
          default: begin
            mac_cmd.a = svhi; mac_cmd.b = shi; mac_cmd.sh = SH_64;
          end
        endcase
      end
      ST_FINISH: begin
        mac_cmd.clr_pos = 1'b1;
        mac_cmd.clr_vel = 1'b1;
      end
      default: mac_cmd.issue = 1'b0;
    endcase
  end

  // Memory ports: one write and one registered read each.
  always_ff @(posedge clk) begin
    if (accept && in_req.action == ACT_LOAD && idx_ext < XW'(COEF_DEPTH)) begin
      coef_mem[idx_ext[AW-1:0]] <= in_req.coef_value;
    end
    if (state_r == ST_MREAD) begin
      cf_q <= coef_mem[addr_r];
      tv_q <= tv_mem[k_r[KW-1:0]];
    end
    if (tv_we) begin
      tv_mem[tv_wa] <= tv_wd;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_FINISH);
      if (state_nxt != state_r) begin
        pc_r <= '0;
      end else if (state_r == ST_REC) begin
        pc_r <= (pc_r == 3'd4) ? 3'd0 : pc_r + 3'd1;
      end else if (state_r == ST_MMUL || state_r == ST_VMUL) begin
        pc_r <= pc_r + 3'd1;
      end
    end
  end

  // Working registers of the evaluation.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (accept) t_r <= t_sat;
      end
      ST_SETUP: begin
        tc_r   <= tc_w[32:0];
        lcnt_r <= l_w;
        base_r <= '0;
      end
      ST_BASE: begin
        if (base_r >= BW'(COEF_DEPTH)) begin
          base_r <= base_r - BW'(COEF_DEPTH);
        end else if (lcnt_r != '0) begin
          base_r <= base_r + BW'(stride);
          lcnt_r <= lcnt_r - 5'd1;
        end
      end
      ST_INIT0: begin
        tm2_r  <= 32'sh4000_0000;
        vm2_r  <= '0;
        addr_r <= base_r[AW-1:0];
        c_r    <= '0;
      end
      ST_INIT1: begin
        tm1_r <= t1_w[31:0];
        vm1_r <= 40'sh00_2000_0000;
        k_r   <= (nt > NTW'(2)) ? NTW'(2) : '0;
      end
      ST_REC: begin
        if (pc_r == 3'd4) begin
          tm2_r <= tm1_r;
          tm1_r <= t_new;
          vm2_r <= vm1_r;
          vm1_r <= v_new;
          k_r   <= k_last ? '0 : k_r + NTW'(1);
        end
      end
      ST_MMUL: begin
        if (pc_r == 3'd5) begin
          addr_r <= addr_inc;
          k_r    <= k_last ? '0 : k_r + NTW'(1);
        end
      end
      ST_VLATCH: sv_r <= round_sat(acc_vel, 29);
      ST_FINISH: begin
        out_res_r.component <= c_r;
        out_res_r.position  <= round_sat(acc_pos, 30);
        out_res_r.velocity  <= cfg.want_vel ? round_sat(acc_vel, 32) : '0;
        out_res_r.last      <= ((c_r + 2'd1) == cfg.num_comp);
        c_r                 <= c_r + 2'd1;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/cse_checker.sv
// Port-level checker for the Chebyshev series evaluator and its bind statement.
`default_nettype none

module cse_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire cse_pkg::in_req_t  in_req,
  input wire logic              out_valid,
  input wire cse_pkg::out_res_t out_res
);
  import cse_pkg::*;

  // Results are never back to back, also across requests.
  a_no_adjacent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("two results in adjacent cycles");

  // A load request leaves the block free in the next cycle.
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req.action == ACT_LOAD) |=> !busy)
    else $error("load request made the block busy");

  // An evaluate request occupies the block.
  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req.action == ACT_EVAL) |=> busy)
    else $error("evaluate request not started");

  // The block stays busy exactly while more components are due.
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (busy == !out_res.last))
    else $error("busy does not match the last flag");

  // A result only follows work in progress.
  a_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without a running request");

endmodule

bind chebyshev_series_eval cse_checker u_cse_checker (.*);

`default_nettype wire

FILE: test/tb.sv
// Self-checking testbench for the Chebyshev series evaluator, with its own predictor.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cse_pkg::*;

  localparam int unsigned STORE_DEPTH = 1024;
  localparam int unsigned PRELOAD_DEPTH = 160;
  localparam logic signed [127:0] WIDE_S64_MAX = 128'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [127:0] WIDE_S64_MIN = -WIDE_S64_MAX - 128'sd1;
  localparam logic [32:0] TIME_ONE = 33'h1_0000_0000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_req_t in_req;
  logic out_valid;
  out_res_t out_res;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [63:0] cfg_wdata;

  chebyshev_series_eval dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_res(out_res),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Clock generation, 12 ns period.
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Predictor state: coefficient store copy and register copy.
  logic signed [63:0] coef_copy [STORE_DEPTH];
  logic [5:0] terms_reg;
  logic [1:0] comps_reg;
  logic [4:0] subint_reg;
  logic vel_on_reg;
  logic signed [63:0] vel_scale_reg;

  out_res_t series_q[$];
  int unsigned mismatches;
  int unsigned unexpected;
  int unsigned evals_sent;
  int unsigned loads_sent;
  int unsigned results_seen;
  bit steady_send;

  // Round x / 2^n half toward plus infinity, saturate to 64 bits signed.
  function automatic logic signed [63:0] round_shift(input logic signed [127:0] x,
                                                     input int n);
    logic signed [127:0] y;
    y = (x + (128'sd1 <<< (n - 1))) >>> n;
    if (y > WIDE_S64_MAX) return WIDE_S64_MAX[63:0];
    if (y < WIDE_S64_MIN) return WIDE_S64_MIN[63:0];
    return y[63:0];
  endfunction

  function automatic logic signed [127:0] wide_mul(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [127:0] wa;
    logic signed [127:0] wb;
    wa = a;
    wb = b;
    return wa * wb;
  endfunction

  function automatic logic signed [63:0] clamp_width(input logic signed [63:0] v,
                                                     input int bits);
    logic signed [63:0] top;
    top = (64'sd1 <<< (bits - 1)) - 64'sd1;
    if (v > top) return top;
    if (v < -top - 64'sd1) return -top - 64'sd1;
    return v;
  endfunction

  // Work out the per-component results of one evaluate request.
  task automatic predict_series(input logic [32:0] tf);
    longint unsigned nt, nc, na, t, prod, frac, l, base;
    logic signed [63:0] tc;
    logic signed [63:0] cheb [32];
    logic signed [63:0] dcheb [32];
    logic signed [127:0] acc_pos, acc_vel;
    logic signed [63:0] cf;
    out_res_t r;
    bit at_one;
    nt = (terms_reg == 0) ? 1 : (terms_reg > 32) ? 32 : terms_reg;
    nc = (comps_reg == 0) ? 1 : comps_reg;
    na = (subint_reg == 0) ? 1 : subint_reg;
    t = (tf > TIME_ONE) ? TIME_ONE : tf;
    at_one = (t == TIME_ONE);
    prod = na * t;
    frac = prod & 64'hFFFF_FFFF;
    l = (prod >> 32) - (at_one ? 1 : 0);
    tc = $signed(frac) + (at_one ? 64'sh1_0000_0000 : 64'sd0) - 64'sh8000_0000;
    // Chebyshev values and their derivatives by recurrence.
    cheb[0] = 64'sh4000_0000;
    cheb[1] = round_shift(wide_mul(tc, 64'sd1), 1);
    dcheb[0] = 0;
    dcheb[1] = 64'sh2000_0000;
    for (int k = 2; k < nt; k++) begin
      cheb[k] = clamp_width(round_shift(wide_mul(tc, cheb[k-1]), 30) - cheb[k-2], 32);
      dcheb[k] = clamp_width(round_shift(wide_mul(tc, dcheb[k-1]), 30) + cheb[k-1]
                             - dcheb[k-2], 40);
    end
    // One result per component, sums taken exactly.
    for (longint unsigned c = 0; c < nc; c++) begin
      base = nt * (c + l * nc);
      acc_pos = 0;
      acc_vel = 0;
      for (longint unsigned k = 0; k < nt; k++) begin
        cf = coef_copy[(base + k) % STORE_DEPTH];
        acc_pos += wide_mul(cheb[k], cf);
        acc_vel += wide_mul(dcheb[k], cf);
      end
      r.component = c[1:0];
      r.position = round_shift(acc_pos, 30);
      r.velocity = vel_on_reg ? round_shift(wide_mul(round_shift(acc_vel, 29),
                                                     vel_scale_reg), 32) : 64'sd0;
      r.last = (c + 1 == nc);
      series_q.push_back(r);
    end
  endtask

  // Send one request; returns at the edge where it was taken, plus any idle gap.
  task automatic send_request(input in_req_t r);
    int g;
    start <= 1'b1;
    in_req <= r;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    if (r.action == ACT_EVAL) begin
      predict_series(r.time_fraction);
      evals_sent++;
    end else begin
      coef_copy[r.coef_index] = r.coef_value;
      loads_sent++;
    end
    g = 0;
    if (!steady_send) begin
      case ($urandom_range(9))
        0, 1, 2: g = $urandom_range(3, 1);
        3: g = $urandom_range(60, 8);
        default: g = 0;
      endcase
    end
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic load_coef(input int idx, input logic [63:0] v);
    in_req_t r;
    r = '0;
    r.action = ACT_LOAD;
    r.coef_index = idx[9:0];
    r.coef_value = v;
    r.time_fraction = {1'b0, $urandom};
    send_request(r);
  endtask

  task automatic evaluate_at(input logic [32:0] tf);
    in_req_t r;
    r.action = ACT_EVAL;
    r.coef_index = 10'($urandom);
    r.coef_value = {$urandom, $urandom};
    r.time_fraction = tf;
    send_request(r);
  endtask

  // Wait until the block is idle and every expected result has arrived.
  task automatic drain_block();
    start <= 1'b0;
    forever begin
      @(posedge clk);
      if (!busy && series_q.size() == 0) break;
    end
    repeat (20) @(posedge clk);
  endtask

  // Drive one register write; the caller drops the write enable after the last one.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    case (idx)
      REG_NUM_TERMS: terms_reg = v[5:0];
      REG_NUM_COMP: comps_reg = v[1:0];
      REG_NUM_SUBINT: subint_reg = v[4:0];
      REG_WANT_VEL: vel_on_reg = v[0];
      REG_VEL_SCALE: vel_scale_reg = v;
      default: ;
    endcase
  endtask

  task automatic set_config(input int nt, input int nc, input int na, input bit vel,
                            input logic [63:0] scale);
    drain_block();
    write_reg(REG_NUM_TERMS, nt);
    write_reg(REG_NUM_COMP, nc);
    write_reg(REG_NUM_SUBINT, na);
    write_reg(REG_WANT_VEL, vel);
    write_reg(REG_VEL_SCALE, scale);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [63:0] random_coef();
    case ($urandom_range(9))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7FFF_FFFF_FFFF_FFFF;
      2, 3: return {{32{$urandom_range(1) == 1}}, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [32:0] random_time();
    longint unsigned na;
    longint unsigned k;
    na = (subint_reg == 0) ? 1 : subint_reg;
    case ($urandom_range(9))
      0: return ($urandom_range(1) == 1) ? TIME_ONE : 33'd0;
      1: begin
        k = $urandom_range(na);
        return 33'((k << 32) / na + $urandom_range(1));
      end
      2: return {1'b1, $urandom};
      default: return {1'b0, $urandom};
    endcase
  endfunction

  // The low store entries get values first; every configuration keeps its reads
  // below that range, so no evaluation touches an entry that was never written.
  task automatic test_preload();
    for (int i = 0; i < PRELOAD_DEPTH; i++) load_coef(i, random_coef());
  endtask

  // Field extremes, time special cases and register extremes.
  task automatic test_directed();
    evaluate_at(33'd0);
    evaluate_at(TIME_ONE);
    evaluate_at(TIME_ONE + 33'd5);
    evaluate_at(33'h1_FFFF_FFFF);
    evaluate_at(33'h0_8000_0000);
    evaluate_at(33'h0_FFFF_FFFF);
    for (int i = 0; i < 4; i++) load_coef(i, 64'h7FFF_FFFF_FFFF_FFFF);
    load_coef(1023, 64'h8000_0000_0000_0000);
    set_config(0, 0, 0, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF);
    evaluate_at(33'd0);
    evaluate_at(TIME_ONE);
    set_config(63, 1, 4, 1'b0, 64'h8000_0000_0000_0000);
    evaluate_at(TIME_ONE);
    evaluate_at(33'h0_4000_0000);
    set_config(1, 3, 31, 1'b1, 64'h8000_0000_0000_0000);
    evaluate_at(TIME_ONE);
    evaluate_at(33'd0);
    evaluate_at(33'h0_1000_0000);
    set_config(32, 3, 1, 1'b1, 64'h8000_0000_0000_0000);
    evaluate_at(TIME_ONE);
    evaluate_at(33'h0_1000_0000);
    set_config(2, 2, 1, 1'b1, 64'h0000_0001_0000_0000);
    evaluate_at(33'h0_C000_0000);
    evaluate_at(33'h1_2345_6789);
  endtask

  // Random phases: a fresh configuration, then mixed loads and evaluations.
  task automatic test_random_phases();
    int nt;
    int nc;
    int na;
    int span;
    logic [63:0] scale;
    for (int p = 0; p < 10; p++) begin
      nt = ($urandom_range(5) == 0) ? $urandom_range(63) : $urandom_range(12, 1);
      nc = $urandom_range(3);
      na = ($urandom_range(4) == 0) ? $urandom_range(31) : $urandom_range(4);
      // Keep all sub-intervals inside the preloaded entries.
      span = ((nt == 0) ? 1 : (nt > 32) ? 32 : nt) * ((nc == 0) ? 1 : nc);
      if (span * ((na == 0) ? 1 : na) > int'(PRELOAD_DEPTH))
        na = int'(PRELOAD_DEPTH) / span;
      scale = ($urandom_range(3) == 0) ? random_coef() : {{30{1'b0}}, $urandom_range(3),
                                                            $urandom};
      set_config(nt, nc, na, $urandom_range(3) != 0, scale);
      steady_send = (p % 4 == 3);
      for (int i = 0; i < 29; i++) begin
        if ($urandom_range(9) < 3) load_coef($urandom_range(1023), random_coef());
        else evaluate_at(random_time());
      end
      steady_send = 1'b0;
    end
  endtask

  // Result checker: each strobed result against the oldest expectation.
  always @(posedge clk) begin
    out_res_t e;
    if (rst_n && out_valid) begin
      results_seen++;
      if (series_q.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= 10)
          $display("tb: unexpected result comp=%0d pos=%h", out_res.component,
                   out_res.position);
      end else begin
        e = series_q.pop_front();
        if (e.component !== out_res.component || e.position !== out_res.position ||
            e.velocity !== out_res.velocity || e.last !== out_res.last) begin
          mismatches++;
          if (mismatches + unexpected <= 10)
            $display("tb: mismatch exp c=%0d p=%h v=%h l=%b got c=%0d p=%h v=%h l=%b",
                     e.component, e.position, e.velocity, e.last, out_res.component,
                     out_res.position, out_res.velocity, out_res.last);
        end
      end
    end
  end

  // Run limit.
  initial begin
    #60_000_000;
    $display("tb: FAIL");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_req = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    terms_reg = 6'd18;
    comps_reg = 2'd1;
    subint_reg = 5'd1;
    vel_on_reg = 1'b1;
    vel_scale_reg = 64'sd0;
    mismatches = 0;
    unexpected = 0;
    evals_sent = 0;
    loads_sent = 0;
    results_seen = 0;
    steady_send = 1'b0;
    for (int i = 0; i < STORE_DEPTH; i++) coef_copy[i] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_preload();
    test_directed();
    test_random_phases();
    drain_block();
    $display("tb: %0d evaluations and %0d coefficient loads sent, %0d results checked",
             evals_sent, loads_sent, results_seen);
    $display("tb: %0d mismatches, %0d unexpected, %0d still outstanding",
             mismatches, unexpected, series_q.size());
    if (mismatches == 0 && unexpected == 0 && series_q.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
hw/rtl/cse_pkg.sv
hw/rtl/cse_mac.sv
hw/rtl/cse_ctrl.sv
hw/rtl/chebyshev_series_eval.sv
hw/rtl/cse_checker.sv
test/tb.sv
